[hdl/assert_macros.svh]
// assertion macros for the rtl files
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond))

`endif

[hdl/stb_pkg.sv]
// shared types and constants of the software timer bank
// no dependencies; imported by stb_mem, stb_ctrl and soft_timer_bank_top
package stb_pkg;

    localparam int ACT_W    = 3;
    localparam int ID_W     = 8;
    localparam int PERIOD_W = 32;
    localparam int RUN_W    = 31;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START_ONE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START_AUTO = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP       = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CHECK      = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd5;

    // run-time counter wraps to zero where it would reach this value
    localparam logic [RUN_W-1:0] RUN_WRAP = 31'h7FFF_FFFF;

    // one timer entry as stored in memory
    typedef struct packed {
        logic                auto_mode;
        logic                expired;
        logic [PERIOD_W-1:0] reload_value;
        logic [PERIOD_W-1:0] remaining;
    } t_entry;

endpackage

[hdl/stb_mem.sv]
// timer state memory: one write port, one read port, registered read data
// depends on stb_pkg; per-entry valid bits make unwritten entries read as zero
module stb_mem
    import stb_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry             r_mem [DEPTH];
    t_entry             r_rd_data;
    logic               r_rd_hit;
    logic [DEPTH-1:0]   r_valid;

    // storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits and read hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    // entry never written reads as its reset value
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

[hdl/stb_ctrl.sv]
// sequencer of the timer bank: decodes actions, runs read-modify-write on
// the state memory, sweeps all entries on a tick and holds the result beat
// depends on stb_pkg
module stb_ctrl
    import stb_pkg::*;
#(
    parameter int TIMERS = 8,
    parameter int IW     = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [ID_W-1:0]     i_timer_id,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic                o_fired,
    output logic [RUN_W-1:0]    o_run_time,
    output logic                o_bad_id,
    output logic                o_rd_en,
    output logic [IW-1:0]       o_rd_addr,
    input  t_entry              i_rd_data,
    output logic                o_wr_en,
    output logic [IW-1:0]       o_wr_addr,
    output t_entry              o_wr_data
);

    localparam int CW = $clog2(TIMERS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_TICK,
        S_DONE
    } t_state;

    t_state              r_state,     n_state;
    logic [ACT_W-1:0]    r_action,    n_action;
    logic [IW-1:0]       r_id,        n_id;
    logic [PERIOD_W-1:0] r_period,    n_period;
    logic [CW-1:0]       r_rd_cnt,    n_rd_cnt;
    logic                r_wb,        n_wb;
    logic [IW-1:0]       r_wb_idx,    n_wb_idx;
    logic [RUN_W-1:0]    r_run,       n_run;
    logic                r_fired,     n_fired;
    logic                r_bad,       n_bad;
    logic                r_out_valid, n_out_valid;
    logic                r_out_fired, n_out_fired;
    logic [RUN_W-1:0]    r_out_run,   n_out_run;
    logic                r_out_bad,   n_out_bad;

    logic   accept;
    logic   in_range;
    logic   is_slot_op;
    logic   sweep_rd;
    t_entry tick_data;
    t_entry mod_data;

    assign accept   = i_s_tvalid && (r_state == S_IDLE);
    assign in_range = i_timer_id < ID_W'(TIMERS);
    assign is_slot_op = (i_action == ACT_START_ONE) || (i_action == ACT_START_AUTO) ||
                        (i_action == ACT_STOP) || (i_action == ACT_CHECK);
    assign sweep_rd = (r_state == S_TICK) && (r_rd_cnt != CW'(TIMERS));

    // memory read: addressed timer on accept, sweep index during a tick
    assign o_rd_en   = (accept && is_slot_op && in_range) || sweep_rd;
    assign o_rd_addr = (r_state == S_TICK) ? r_rd_cnt[IW-1:0] : i_timer_id[IW-1:0];

    // one tick applied to an entry
    always_comb begin
        tick_data = i_rd_data;
        if (i_rd_data.remaining != '0) begin
            tick_data.remaining = i_rd_data.remaining - 1'b1;
            if (i_rd_data.remaining == PERIOD_W'(1)) begin
                tick_data.expired   = 1'b1;
                tick_data.remaining = i_rd_data.auto_mode ? i_rd_data.reload_value : '0;
            end
        end
    end

    // start, stop and check applied to an entry
    always_comb begin
        mod_data = i_rd_data;
        case (r_action)
            ACT_START_ONE, ACT_START_AUTO: begin
                mod_data.remaining    = r_period;
                mod_data.reload_value = r_period;
                mod_data.expired      = 1'b0;
                mod_data.auto_mode    = (r_action == ACT_START_AUTO);
            end
            ACT_STOP: begin
                mod_data.remaining = '0;
                mod_data.expired   = 1'b0;
                mod_data.auto_mode = 1'b0;
            end
            ACT_CHECK: begin
                mod_data.expired = 1'b0;
            end
            default: begin
                mod_data = i_rd_data;
            end
        endcase
    end

    // memory write-back
    assign o_wr_en   = (r_state == S_MOD) || ((r_state == S_TICK) && r_wb);
    assign o_wr_addr = (r_state == S_TICK) ? r_wb_idx : r_id;
    assign o_wr_data = (r_state == S_TICK) ? tick_data : mod_data;

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_id        = r_id;
        n_period    = r_period;
        n_rd_cnt    = r_rd_cnt;
        n_wb        = r_wb;
        n_wb_idx    = r_wb_idx;
        n_run       = r_run;
        n_fired     = r_fired;
        n_bad       = r_bad;
        n_out_valid = r_out_valid;
        n_out_fired = r_out_fired;
        n_out_run   = r_out_run;
        n_out_bad   = r_out_bad;

        // result beat taken downstream
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_id     = i_timer_id[IW-1:0];
                    n_period = i_period;
                    n_fired  = 1'b0;
                    n_bad    = 1'b0;
                    n_rd_cnt = '0;
                    n_wb     = 1'b0;
                    if (i_action == ACT_TICK) begin
                        n_state = S_TICK;
                    end else if (is_slot_op) begin
                        if (in_range) begin
                            n_state = S_MOD;
                        end else begin
                            n_bad   = 1'b1;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOD: begin
                n_fired = (r_action == ACT_CHECK) && i_rd_data.expired;
                n_state = S_DONE;
            end
            S_TICK: begin
                if (sweep_rd) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                n_wb     = sweep_rd;
                n_wb_idx = r_rd_cnt[IW-1:0];
                if (r_wb && (r_wb_idx == IW'(TIMERS - 1))) begin
                    n_wb    = 1'b0;
                    n_run   = (r_run == RUN_WRAP - 1'b1) ? '0 : r_run + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_fired = r_fired;
                    n_out_run   = r_run;
                    n_out_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_cnt    <= '0;
            r_wb        <= 1'b0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_cnt    <= n_rd_cnt;
            r_wb        <= n_wb;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
        r_action    <= n_action;
        r_id        <= n_id;
        r_period    <= n_period;
        r_wb_idx    <= n_wb_idx;
        r_fired     <= n_fired;
        r_bad       <= n_bad;
        r_out_fired <= n_out_fired;
        r_out_run   <= n_out_run;
        r_out_bad   <= n_out_bad;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_fired    = r_out_fired;
    assign o_run_time = r_out_run;
    assign o_bad_id   = r_out_bad;

endmodule

[hdl/soft_timer_bank_top.sv]
// path: start, stop and check go from accept through S_MOD and S_DONE into the
// output register, read and bad ids through S_DONE alone; a tick sweeps all entries
// through the memory read and write ports and one decrementer, then goes to S_DONE
// throughput: one item in flight; the next is accepted once the result is in
// the output register. reset: synchronous active-low, clears all timers
// through per-entry valid bits and the run-time counter, no clearing pass
module soft_timer_bank_top
    import stb_pkg::*;
#(
    parameter int TIMERS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // timer_id[7:0], period[39:8]
    input  logic [2:0]  i_s_tuser,   // action[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // fired[0], run_time[31:1], bad_id[32], zero pad
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    t_entry           rd_data;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    t_entry           wr_data;
    logic             fired;
    logic [RUN_W-1:0] run_time;
    logic             bad_id;

    // sequencer
    stb_ctrl #(
        .TIMERS (TIMERS),
        .IW     (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tuser),
        .i_timer_id (i_s_tdata[7:0]),
        .i_period   (i_s_tdata[39:8]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_fired    (fired),
        .o_run_time (run_time),
        .o_bad_id   (bad_id),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    // timer state memory
    stb_mem #(
        .DEPTH (TIMERS),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // result beat packing
    assign o_m_tdata = {7'd0, bad_id, run_time, fired};

`include "assert_macros.svh"

    // sweep never writes back the entry it is reading
    `ASSERT_NEVER(a_no_rw_same_entry, i_clk, i_rst_n, rd_en && wr_en && (rd_addr == wr_addr))

    // one item at a time: ready drops right after an accepted beat
    `ASSERT_CLK(a_ready_drops, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready)

    // a result never reports a fired flag and a bad id together
    `ASSERT_NEVER(a_fired_bad_excl, i_clk, i_rst_n, o_m_tvalid && fired && bad_id)

endmodule

[test/soft_timer_bank_checker.sv]
// checker for the software timer bank: watches both stream channels, predicts
// each result beat from its own copy of the timer state and compares it
// depends on stb_pkg for widths, action codes and the timer entry type
`timescale 1ns / 1ps

module soft_timer_bank_checker
    import stb_pkg::*;
#(
    parameter int TIMERS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // timer_id[7:0], period[39:8]
    input  logic [2:0]  i_s_tuser,   // action[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // fired[0], run_time[31:1], bad_id[32], zero pad
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_fired,
    output int          o_bad_ids
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    // one result beat split into its fields
    typedef struct packed {
        logic             fired;
        logic [RUN_W-1:0] run_time;
        logic             bad_id;
    } t_reply;

    t_entry           timers [TIMERS];
    logic [RUN_W-1:0] run_ticks;
    t_reply           due_replies [$];

    // one tick: count down every running timer, flag at zero and reload auto-mode timers
    task automatic tick_timers();
        for (int k = 0; k < TIMERS; k++) begin
            if (timers[k].remaining != '0) begin
                timers[k].remaining = timers[k].remaining - 1'b1;
                if (timers[k].remaining == '0) begin
                    timers[k].expired = 1'b1;
                    if (timers[k].auto_mode)
                        timers[k].remaining = timers[k].reload_value;
                end
            end
        end
        run_ticks = run_ticks + 1'b1;
        if (run_ticks == RUN_WRAP)
            run_ticks = '0;
    endtask

    // apply one action to the predicted bank and form its result
    task automatic apply_action(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                                input logic [PERIOD_W-1:0] period, output t_reply rep);
        logic          known;
        logic [IW-1:0] slot;
        known = (id < TIMERS);
        slot  = id[IW-1:0];
        rep = '0;
        case (act)
            ACT_TICK: begin
                tick_timers();
            end
            ACT_START_ONE, ACT_START_AUTO: begin
                if (known) begin
                    timers[slot].remaining    = period;
                    timers[slot].reload_value = period;
                    timers[slot].expired      = 1'b0;
                    timers[slot].auto_mode    = (act == ACT_START_AUTO);
                end else begin
                    rep.bad_id = 1'b1;
                end
            end
            ACT_STOP: begin
                if (known) begin
                    timers[slot].remaining = '0;
                    timers[slot].expired   = 1'b0;
                    timers[slot].auto_mode = 1'b0;
                end else begin
                    rep.bad_id = 1'b1;
                end
            end
            ACT_CHECK: begin
                if (known) begin
                    rep.fired = timers[slot].expired;
                    timers[slot].expired = 1'b0;
                end else begin
                    rep.bad_id = 1'b1;
                end
            end
            default: begin
            end
        endcase
        rep.run_time = run_ticks;
    endtask

    // compare result beats first, then predict the beat accepted at the same edge
    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        t_reply rep;
        if (!i_rst_n) begin
            for (int k = 0; k < TIMERS; k++)
                timers[k] = '0;
            run_ticks = '0;
            due_replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{fired: i_m_tdata[0], run_time: i_m_tdata[31:1], bad_id: i_m_tdata[32]};
                o_results++;
                if (got.fired === 1'b1)
                    o_fired++;
                if (got.bad_id === 1'b1)
                    o_bad_ids++;
                if (due_replies.size() == 0) begin
                    $display("%0t: result beat with none expected, got %h", $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = due_replies.pop_front();
                    if (got.fired !== want.fired) begin
                        $display("%0t: fired mismatch, expected %0d, got %0d",
                                 $time, want.fired, got.fired);
                        o_fail_count++;
                    end
                    if (got.run_time !== want.run_time) begin
                        $display("%0t: run_time mismatch, expected %h, got %h",
                                 $time, want.run_time, got.run_time);
                        o_fail_count++;
                    end
                    if (got.bad_id !== want.bad_id) begin
                        $display("%0t: bad_id mismatch, expected %0d, got %0d",
                                 $time, want.bad_id, got.bad_id);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_action(i_s_tuser, i_s_tdata[7:0], i_s_tdata[39:8], rep);
                due_replies.push_back(rep);
            end
        end
        o_pending = due_replies.size();
    end

endmodule

[test/soft_timer_bank_top_tb.sv]
// testbench top for the software timer bank: clock, reset, directed and random
// action beats under several handshake phases, and the final verdict
// depends on stb_pkg, soft_timer_bank_top and soft_timer_bank_checker
`timescale 1ns / 1ps

module soft_timer_bank_top_tb;
    import stb_pkg::*;

    localparam int TIMERS = 8;
    localparam int PHASE_BEATS = 160;
    // action codes the block leaves unused
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // timer_id[7:0], period[39:8]
    logic [2:0]  i_s_tuser;   // action[2:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;   // fired[0], run_time[31:1], bad_id[32], zero pad

    int fail_count;
    int pending;
    int results;
    int fired_count;
    int bad_count;
    int sent_beats;
    int send_idle_pct;
    int recv_stall_pct;

    soft_timer_bank_top #(
        .TIMERS (TIMERS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    soft_timer_bank_checker #(
        .TIMERS (TIMERS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_fired      (fired_count),
        .o_bad_ids    (bad_count)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // receiver side: stall at random at the falling edge
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // one action beat: optional idle cycles, then hold until accepted
    task automatic send_action(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                               input logic [PERIOD_W-1:0] period);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {period, id};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        sent_beats++;
    endtask

    // mostly short periods so timers expire often, with the extremes mixed in
    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // random beat weighted toward ticks, starts and checks
    task automatic send_random_action();
        int                  pick;
        logic [ACT_W-1:0]    act;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        pick   = $urandom_range(0, 99);
        period = $urandom;
        id     = ID_W'($urandom);
        if (pick < 35)
            act = ACT_TICK;
        else if (pick < 47)
            act = ACT_START_ONE;
        else if (pick < 59)
            act = ACT_START_AUTO;
        else if (pick < 66)
            act = ACT_STOP;
        else if (pick < 88)
            act = ACT_CHECK;
        else if (pick < 95)
            act = ACT_READ;
        else
            act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        if (act inside {ACT_START_ONE, ACT_START_AUTO, ACT_STOP, ACT_CHECK}) begin
            if ($urandom_range(0, 9) == 0)
                id = ID_W'($urandom_range(TIMERS, 255));
            else
                id = ID_W'($urandom_range(0, TIMERS - 1));
        end
        if (act inside {ACT_START_ONE, ACT_START_AUTO})
            period = pick_period();
        send_action(act, id, period);
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        sent_beats     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: expiry, check clearing, reload, stop, idle timers, bad ids
        send_action(ACT_TICK, 8'h00, 32'h0);
        send_action(ACT_READ, 8'hFF, 32'hFFFF_FFFF);
        send_action(ACT_START_ONE, 8'h00, 32'h1);
        send_action(ACT_START_AUTO, 8'h01, 32'h2);
        send_action(ACT_START_ONE, ID_W'(TIMERS - 1), 32'hFFFF_FFFF);
        send_action(ACT_START_AUTO, 8'h02, 32'h0);
        send_action(ACT_TICK, 8'h00, 32'h0);
        send_action(ACT_CHECK, 8'h00, 32'h0);
        send_action(ACT_CHECK, 8'h00, 32'h0);
        send_action(ACT_TICK, 8'h00, 32'h0);
        send_action(ACT_CHECK, 8'h01, 32'h0);
        send_action(ACT_CHECK, 8'h02, 32'h0);
        send_action(ACT_STOP, 8'h01, 32'h0);
        send_action(ACT_TICK, 8'h00, 32'h0);
        send_action(ACT_TICK, 8'h00, 32'h0);
        send_action(ACT_CHECK, 8'h01, 32'h0);
        send_action(ACT_START_ONE, ID_W'(TIMERS), 32'h5);
        send_action(ACT_START_AUTO, 8'hFF, 32'h0);
        send_action(ACT_STOP, 8'hFF, 32'h0);
        send_action(ACT_CHECK, 8'h80, 32'h0);
        send_action(ACT_SPARE_LO, 8'h00, 32'h1);
        send_action(ACT_SPARE_HI, 8'h03, 32'hFFFF_FFFF);
        send_action(ACT_CHECK, ID_W'(TIMERS - 1), 32'h0);
        send_action(ACT_READ, 8'h00, 32'h0);

        // random: no idling, sender idle, receiver stalls, light idling on both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // hold off once until the block has drained
                if (ph == 2 && n == PHASE_BEATS / 2) begin
                    i_s_tvalid <= 1'b0;
                    @(negedge i_clk);
                    while (pending != 0) @(negedge i_clk);
                end
                send_random_action();
            end
        end
        i_s_tvalid     <= 1'b0;
        recv_stall_pct = 0;

        // drain, then allow a full tick sweep for stray beats
        while (pending != 0) @(negedge i_clk);
        repeat (TIMERS + 8) @(negedge i_clk);

        $display("covered %0d action beats over four handshake phases, %0d results checked",
                 sent_beats, results);
        $display("%0d checks saw an expired timer, %0d beats named a timer out of range",
                 fired_count, bad_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
